FILE: src/sakth_pkg.sv
package sakth_pkg;

  // Field widths fixed by the word formats.
  localparam int OPC_W  = 2;
  localparam int SYM_W  = 5;
  localparam int RANK_W = 12;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 12;

  // Operation codes.
  localparam logic [OPC_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPC_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [SYM_W-1:0]  symbol_in;
    logic [RANK_W-1:0] rank;
  } in_word_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol_out;
    logic              last_of_run;
    logic [STAT_W-1:0] status;
  } out_word_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_A_NEW, S_A_ZERO, S_W1_CHK, S_W1_LNK, S_A_LP, S_A_LQ,
    S_C_LNK, S_C_CPY, S_W2_CHK, S_W2_LNK, S_C_FIX1, S_C_FIX2, S_A_FIN,
    S_B_CLR, S_B_HL, S_B_HB, S_B_P0, S_B_P, S_B_SL, S_B_SB,
    S_D_RO, S_D_U, S_D_T, S_D_P,
    S_Q_ROOT, S_Q_CHK, S_Q_T, S_Q_P, S_Q_END, S_ERR
  } state_t;

endpackage

FILE: src/suffix_automaton_kth_substring.sv
// Channel  Ports                          Word
// -------  -----------------------------  -----------------------------------
// input    in_valid, in_ready, in_data    opcode, symbol_in, rank
// output   out_valid, out_ready, out_data symbol_out, last_of_run, status
//
// One word is worked at a time. An append zeroes the new node's transition row, walks the
// suffix links adding edges and, when an edge exists, may clone a node and redirect edges.
// The first query after appends or a clear sorts the nodes by length and counts the paths
// of each node; each letter of the answer then scans the transition row of the current node.
// After reset or a clear word, the root's transition row is zeroed.
// A stalled output holds the result register and, on the next letter, the walk.
module suffix_automaton_kth_substring
  import sakth_pkg::*;
#(
  parameter int MAX_TEXT = 64,
  parameter int ALPHABET = 26
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int NODES = 2 * MAX_TEXT;
  localparam int NW    = $clog2(NODES);
  localparam int TW    = $clog2(NODES + 1);
  localparam int LW    = $clog2(MAX_TEXT + 1);
  localparam int BKD   = MAX_TEXT + 2;
  localparam int BKAW  = $clog2(BKD);
  localparam int TAW   = NW + SYM_W;
  localparam logic [SYM_W-1:0] ALPHA_LAST = SYM_W'(ALPHABET - 1);

  // Control and working registers.
  state_t            state_r, state_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  logic [NW-1:0]     newest_r, newest_nxt;
  logic [LW-1:0]     textlen_r, textlen_nxt;
  logic              fresh_r, fresh_nxt;
  logic [NW-1:0]     cur_r, cur_nxt;
  logic [NW-1:0]     p_r, p_nxt;
  logic [NW-1:0]     q_r, q_nxt;
  logic [NW-1:0]     cl_r, cl_nxt;
  logic [NW-1:0]     u_r, u_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [SYM_W-1:0]  a_r, a_nxt;
  logic [RANK_W-1:0] k_r, k_nxt;
  logic [LW-1:0]     n_r, n_nxt;
  logic [LW-1:0]     lenp_r, lenp_nxt;
  logic [CNT_W-1:0]  sum_r, sum_nxt;
  logic [TW-1:0]     idx_r, idx_nxt;
  logic [TW-1:0]     run_r, run_nxt;
  logic [BKAW-1:0]   lv_r, lv_nxt;
  logic [SYM_W-1:0]  pend_r, pend_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  // Memory ports.
  logic              len_we, lnk_we, trn_we, pc_we, ord_we, bk_we;
  logic [NW-1:0]     len_wa, len_ra, lnk_wa, lnk_ra, pc_wa, pc_ra, ord_wa, ord_ra;
  logic [TAW-1:0]    trn_wa, trn_ra;
  logic [BKAW-1:0]   bk_wa, bk_ra;
  logic [LW-1:0]     len_wd, len_rd;
  logic [NW-1:0]     lnk_wd, lnk_rd, trn_wd, trn_rd, ord_wd, ord_rd;
  logic [CNT_W-1:0]  pc_wd, pc_rd;
  logic [TW-1:0]     bk_wd, bk_rd;

  sakth_ram #(.W(LW), .D(NODES)) u_len (
    .clk(clk), .we(len_we), .waddr(len_wa), .wdata(len_wd), .raddr(len_ra), .rdata(len_rd));
  sakth_ram #(.W(NW), .D(NODES)) u_link (
    .clk(clk), .we(lnk_we), .waddr(lnk_wa), .wdata(lnk_wd), .raddr(lnk_ra), .rdata(lnk_rd));
  sakth_ram #(.W(NW), .D(NODES << SYM_W)) u_trans (
    .clk(clk), .we(trn_we), .waddr(trn_wa), .wdata(trn_wd), .raddr(trn_ra), .rdata(trn_rd));
  sakth_ram #(.W(CNT_W), .D(NODES)) u_paths (
    .clk(clk), .we(pc_we), .waddr(pc_wa), .wdata(pc_wd), .raddr(pc_ra), .rdata(pc_rd));
  sakth_ram #(.W(NW), .D(NODES)) u_order (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd));
  sakth_ram #(.W(TW), .D(BKD)) u_bucket (
    .clk(clk), .we(bk_we), .waddr(bk_wa), .wdata(bk_wd), .raddr(bk_ra), .rdata(bk_rd));

  // Shared decisions.
  logic in_fire, out_free, a_last, store_full, sym_bad, trn_zero;
  logic q_take, pend_ok, q_stop, range_err, len_match, last_node, bk_end, idx_one;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign a_last     = (a_r == ALPHA_LAST);
  assign store_full = (textlen_r == LW'(MAX_TEXT)) ||
                      (({1'b0, total_r} + (TW+1)'(2)) > (TW+1)'(NODES));
  assign sym_bad    = (in_data.symbol_in > ALPHA_LAST);
  assign trn_zero   = (trn_rd == '0);
  assign q_take     = (k_r <= pc_rd);
  assign pend_ok    = !pend_v_r || out_free;
  assign q_stop     = (k_r == RANK_W'(1)) || ((n_r + LW'(1)) == LW'(MAX_TEXT));
  assign range_err  = (k_r == '0) || ((pc_rd != '0) && (k_r >= pc_rd));
  assign len_match  = ((lenp_r + LW'(1)) == len_rd);
  assign last_node  = ((idx_r + TW'(1)) == total_r);
  assign bk_end     = (idx_r == TW'(BKD - 1));
  assign idx_one    = (idx_r == TW'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:    if (a_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.opcode)
            OP_CLEAR:  state_nxt = S_CLR;
            OP_APPEND: begin
              if (store_full) state_nxt = S_ERR;
              else if (!sym_bad) state_nxt = S_A_NEW;
            end
            OP_QUERY:  state_nxt = fresh_r ? S_Q_ROOT : S_B_CLR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_A_NEW:  state_nxt = S_A_ZERO;
      S_A_ZERO: if (a_last) state_nxt = S_W1_CHK;
      S_W1_CHK: begin
        if (!trn_zero) state_nxt = S_A_LP;
        else if (p_r == '0) state_nxt = S_A_FIN;
        else state_nxt = S_W1_LNK;
      end
      S_W1_LNK: state_nxt = S_W1_CHK;
      S_A_LP:   state_nxt = S_A_LQ;
      S_A_LQ:   state_nxt = len_match ? S_A_FIN : S_C_LNK;
      S_C_LNK:  state_nxt = S_C_CPY;
      S_C_CPY:  if (a_last) state_nxt = S_W2_CHK;
      S_W2_CHK: begin
        if ((trn_rd == q_r) && (p_r != '0)) state_nxt = S_W2_LNK;
        else state_nxt = S_C_FIX1;
      end
      S_W2_LNK: state_nxt = S_W2_CHK;
      S_C_FIX1: state_nxt = S_C_FIX2;
      S_C_FIX2: state_nxt = S_A_FIN;
      S_A_FIN:  state_nxt = S_IDLE;
      S_B_CLR:  if (bk_end) state_nxt = S_B_HL;
      S_B_HL:   state_nxt = S_B_HB;
      S_B_HB:   state_nxt = last_node ? S_B_P0 : S_B_HL;
      S_B_P0:   state_nxt = S_B_P;
      S_B_P:    if (bk_end) state_nxt = S_B_SL;
      S_B_SL:   state_nxt = S_B_SB;
      S_B_SB:   state_nxt = last_node ? S_D_RO : S_B_SL;
      S_D_RO:   state_nxt = S_D_U;
      S_D_U:    state_nxt = S_D_T;
      S_D_T: begin
        if (!trn_zero) state_nxt = S_D_P;
        else if (a_last) state_nxt = idx_one ? S_Q_ROOT : S_D_RO;
      end
      S_D_P: begin
        if (a_last) state_nxt = idx_one ? S_Q_ROOT : S_D_RO;
        else state_nxt = S_D_T;
      end
      S_Q_ROOT: state_nxt = S_Q_CHK;
      S_Q_CHK:  state_nxt = range_err ? S_ERR : S_Q_T;
      S_Q_T: begin
        if (!trn_zero) state_nxt = S_Q_P;
        else if (a_last) state_nxt = S_Q_END;
      end
      S_Q_P: begin
        if (!q_take) state_nxt = a_last ? S_Q_END : S_Q_T;
        else if (pend_ok) state_nxt = q_stop ? S_Q_END : S_Q_T;
      end
      S_Q_END: begin
        if (!pend_v_r) state_nxt = S_ERR;
        else if (out_free) state_nxt = S_IDLE;
      end
      S_ERR:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory controls and result pushes.
  logic      push;
  out_word_t push_word;
  logic [CNT_W-1:0] sum_add;

  assign sum_add = sum_r + pc_rd;

  always_comb begin
    total_nxt   = total_r;
    newest_nxt  = newest_r;
    textlen_nxt = textlen_r;
    fresh_nxt   = fresh_r;
    cur_nxt     = cur_r;
    p_nxt       = p_r;
    q_nxt       = q_r;
    cl_nxt      = cl_r;
    u_nxt       = u_r;
    sym_nxt     = sym_r;
    a_nxt       = a_r;
    k_nxt       = k_r;
    n_nxt       = n_r;
    lenp_nxt    = lenp_r;
    sum_nxt     = sum_r;
    idx_nxt     = idx_r;
    run_nxt     = run_r;
    lv_nxt      = lv_r;
    pend_nxt    = pend_r;
    pend_v_nxt  = pend_v_r;
    st_nxt      = st_r;
    push        = 1'b0;
    push_word   = '0;
    len_we = 1'b0; len_wa = '0; len_wd = '0; len_ra = '0;
    lnk_we = 1'b0; lnk_wa = '0; lnk_wd = '0; lnk_ra = '0;
    trn_we = 1'b0; trn_wa = '0; trn_wd = '0; trn_ra = '0;
    pc_we  = 1'b0; pc_wa  = '0; pc_wd  = '0; pc_ra  = '0;
    ord_we = 1'b0; ord_wa = '0; ord_wd = '0; ord_ra = '0;
    bk_we  = 1'b0; bk_wa  = '0; bk_wd  = '0; bk_ra  = '0;

    case (state_r)
      // Zero the root row and root length.
      S_CLR: begin
        trn_we = 1'b1;
        trn_wa = {NW'(0), a_r};
        len_we = 1'b1;
        a_nxt  = a_last ? '0 : a_r + SYM_W'(1);
      end
      S_IDLE: begin
        len_ra = newest_r;
        if (in_fire) begin
          case (in_data.opcode)
            OP_CLEAR: begin
              total_nxt   = TW'(1);
              newest_nxt  = '0;
              textlen_nxt = '0;
              fresh_nxt   = 1'b0;
              a_nxt       = '0;
            end
            OP_APPEND: begin
              if (store_full) begin
                st_nxt = ST_FULL;
              end else if (!sym_bad) begin
                cur_nxt   = total_r[NW-1:0];
                total_nxt = total_r + TW'(1);
                sym_nxt   = in_data.symbol_in;
                p_nxt     = newest_r;
              end
            end
            OP_QUERY: begin
              k_nxt   = in_data.rank;
              idx_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      // New node: length and an empty transition row.
      S_A_NEW: begin
        len_we = 1'b1;
        len_wa = cur_r;
        len_wd = len_rd + LW'(1);
        a_nxt  = '0;
      end
      S_A_ZERO: begin
        trn_we = 1'b1;
        trn_wa = {cur_r, a_r};
        trn_ra = {p_r, sym_r};
        a_nxt  = a_last ? '0 : a_r + SYM_W'(1);
      end
      // First suffix link walk: add edges to the new node.
      S_W1_CHK: begin
        if (trn_zero) begin
          trn_we = 1'b1;
          trn_wa = {p_r, sym_r};
          trn_wd = cur_r;
          if (p_r == '0) begin
            lnk_we = 1'b1;
            lnk_wa = cur_r;
          end else begin
            lnk_ra = p_r;
          end
        end else begin
          q_nxt  = trn_rd;
          len_ra = p_r;
        end
      end
      S_W1_LNK, S_W2_LNK: begin
        p_nxt  = lnk_rd;
        trn_ra = {lnk_rd, sym_r};
      end
      S_A_LP: begin
        lenp_nxt = len_rd;
        len_ra   = q_r;
      end
      S_A_LQ: begin
        if (len_match) begin
          lnk_we = 1'b1;
          lnk_wa = cur_r;
          lnk_wd = q_r;
        end else begin
          cl_nxt    = total_r[NW-1:0];
          total_nxt = total_r + TW'(1);
          len_we    = 1'b1;
          len_wa    = total_r[NW-1:0];
          len_wd    = lenp_r + LW'(1);
          lnk_ra    = q_r;
        end
      end
      // Clone: copy the link and the transition row.
      S_C_LNK: begin
        lnk_we = 1'b1;
        lnk_wa = cl_r;
        lnk_wd = lnk_rd;
        a_nxt  = '0;
        trn_ra = {q_r, SYM_W'(0)};
      end
      S_C_CPY: begin
        trn_we = 1'b1;
        trn_wa = {cl_r, a_r};
        trn_wd = trn_rd;
        if (a_last) begin
          a_nxt  = '0;
          trn_ra = {p_r, sym_r};
        end else begin
          a_nxt  = a_r + SYM_W'(1);
          trn_ra = {q_r, a_r + SYM_W'(1)};
        end
      end
      // Second walk: redirect edges from the old node to the clone.
      S_W2_CHK: begin
        if (trn_rd == q_r) begin
          trn_we = 1'b1;
          trn_wa = {p_r, sym_r};
          trn_wd = cl_r;
          lnk_ra = p_r;
        end
      end
      S_C_FIX1: begin
        lnk_we = 1'b1;
        lnk_wa = q_r;
        lnk_wd = cl_r;
      end
      S_C_FIX2: begin
        lnk_we = 1'b1;
        lnk_wa = cur_r;
        lnk_wd = cl_r;
      end
      S_A_FIN: begin
        newest_nxt  = cur_r;
        textlen_nxt = textlen_r + LW'(1);
        fresh_nxt   = 1'b0;
      end
      // Counting sort by length: clear buckets.
      S_B_CLR: begin
        bk_we   = 1'b1;
        bk_wa   = idx_r[BKAW-1:0];
        idx_nxt = bk_end ? '0 : idx_r + TW'(1);
      end
      // Histogram of lengths.
      S_B_HL: begin
        lv_nxt = BKAW'(len_rd) + BKAW'(1);
        bk_ra  = BKAW'(len_rd) + BKAW'(1);
      end
      S_B_HB: begin
        bk_we = 1'b1;
        bk_wa = lv_r;
        bk_wd = bk_rd + TW'(1);
        if (last_node) begin
          idx_nxt = TW'(1);
        end else begin
          idx_nxt = idx_r + TW'(1);
          len_ra  = NW'(idx_r + TW'(1));
        end
      end
      // Running prefix sum over buckets.
      S_B_P0: begin
        run_nxt = bk_rd;
        bk_ra   = idx_r[BKAW-1:0];
      end
      S_B_P: begin
        bk_we   = 1'b1;
        bk_wa   = idx_r[BKAW-1:0];
        bk_wd   = run_r + bk_rd;
        run_nxt = run_r + bk_rd;
        if (bk_end) begin
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + TW'(1);
          bk_ra   = BKAW'(idx_r + TW'(1));
        end
      end
      // Scatter nodes into length order.
      S_B_SL: begin
        lv_nxt = BKAW'(len_rd);
        bk_ra  = BKAW'(len_rd);
      end
      S_B_SB: begin
        ord_we = 1'b1;
        ord_wa = bk_rd[NW-1:0];
        ord_wd = idx_r[NW-1:0];
        bk_we  = 1'b1;
        bk_wa  = lv_r;
        bk_wd  = bk_rd + TW'(1);
        if (last_node) begin
          idx_nxt = total_r;
        end else begin
          idx_nxt = idx_r + TW'(1);
          len_ra  = NW'(idx_r + TW'(1));
        end
      end
      // Path counts from the longest node down.
      S_D_RO: begin
        ord_ra = NW'(idx_r - TW'(1));
      end
      S_D_U: begin
        u_nxt   = ord_rd;
        sum_nxt = CNT_W'(1);
        a_nxt   = '0;
        trn_ra  = {ord_rd, SYM_W'(0)};
      end
      S_D_T: begin
        trn_ra = {u_r, a_r};
        if (!trn_zero) begin
          pc_ra = trn_rd;
        end else if (a_last) begin
          pc_we   = 1'b1;
          pc_wa   = u_r;
          pc_wd   = sum_r;
          idx_nxt = idx_r - TW'(1);
          a_nxt   = '0;
          if (idx_one) fresh_nxt = 1'b1;
        end else begin
          a_nxt  = a_r + SYM_W'(1);
          trn_ra = {u_r, a_r + SYM_W'(1)};
        end
      end
      S_D_P: begin
        sum_nxt = sum_add;
        if (a_last) begin
          pc_we   = 1'b1;
          pc_wa   = u_r;
          pc_wd   = sum_add;
          idx_nxt = idx_r - TW'(1);
          a_nxt   = '0;
          if (idx_one) fresh_nxt = 1'b1;
        end else begin
          a_nxt  = a_r + SYM_W'(1);
          trn_ra = {u_r, a_r + SYM_W'(1)};
        end
      end
      // Query: check the rank against the root count.
      S_Q_ROOT: begin
        pc_ra = '0;
      end
      S_Q_CHK: begin
        if (range_err) begin
          st_nxt = ST_RANGE;
        end else begin
          u_nxt      = '0;
          a_nxt      = '0;
          n_nxt      = '0;
          pend_v_nxt = 1'b0;
          trn_ra     = '0;
        end
      end
      // Query walk over the letters of the current node.
      S_Q_T: begin
        trn_ra = {u_r, a_r};
        if (!trn_zero) begin
          pc_ra = trn_rd;
        end else if (!a_last) begin
          a_nxt  = a_r + SYM_W'(1);
          trn_ra = {u_r, a_r + SYM_W'(1)};
        end
      end
      S_Q_P: begin
        trn_ra = {u_r, a_r};
        pc_ra  = trn_rd;
        if (!q_take) begin
          k_nxt = k_r - pc_rd;
          if (!a_last) begin
            a_nxt  = a_r + SYM_W'(1);
            trn_ra = {u_r, a_r + SYM_W'(1)};
          end
        end else if (pend_ok) begin
          if (pend_v_r) begin
            push      = 1'b1;
            push_word = '{symbol_out: pend_r, last_of_run: 1'b0, status: ST_OK};
          end
          u_nxt      = trn_rd;
          k_nxt      = k_r - RANK_W'(1);
          pend_nxt   = a_r;
          pend_v_nxt = 1'b1;
          n_nxt      = n_r + LW'(1);
          a_nxt      = '0;
          trn_ra     = {trn_rd, SYM_W'(0)};
        end
      end
      S_Q_END: begin
        if (!pend_v_r) begin
          st_nxt = ST_RANGE;
        end else if (out_free) begin
          push       = 1'b1;
          push_word  = '{symbol_out: pend_r, last_of_run: 1'b1, status: ST_OK};
          pend_v_nxt = 1'b0;
        end
      end
      S_ERR: begin
        if (out_free) begin
          push      = 1'b1;
          push_word = '{symbol_out: '0, last_of_run: 1'b1, status: st_r};
        end
      end
      default: ;
    endcase

    // Output register.
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = push_word;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Register update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      a_r         <= '0;
      total_r     <= TW'(1);
      newest_r    <= '0;
      textlen_r   <= '0;
      fresh_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_r         <= a_nxt;
      total_r     <= total_nxt;
      newest_r    <= newest_nxt;
      textlen_r   <= textlen_nxt;
      fresh_r     <= fresh_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    cl_r       <= cl_nxt;
    u_r        <= u_nxt;
    sym_r      <= sym_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    lenp_r     <= lenp_nxt;
    sum_r      <= sum_nxt;
    idx_r      <= idx_nxt;
    run_r      <= run_nxt;
    lv_r       <= lv_nxt;
    pend_r     <= pend_nxt;
    st_r       <= st_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

FILE: src/sakth_ram.sv
module sakth_ram #(
  parameter int W = 8,
  parameter int D = 128
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
